FILE: rtl/dsp_pkg.sv
package dsp_pkg;

    localparam int DATA_DEPTH   = 32;
    localparam int RETURN_DEPTH = 32;

    localparam int WORD_W      = 64;
    localparam int HALF_W      = WORD_W / 2;
    localparam int KIND_W      = 5;
    localparam int KEY_W       = 9;
    localparam int STATUS_W    = 3;
    localparam int CHAR_W      = 8;
    localparam int DEPTH_OUT_W = 6;
    localparam int DP_W        = $clog2(DATA_DEPTH + 1);
    localparam int RP_W        = $clog2(RETURN_DEPTH + 1);

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_PREV,
        SHIFT_NEXT
    } cell_shift_t;

    typedef struct packed {
        cell_shift_t shift;
        logic        load;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        AR_MUL,
        AR_DIV,
        AR_REM,
        AR_MOD
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    localparam logic [KIND_W-1:0] K_LIT    = 5'd0;
    localparam logic [KIND_W-1:0] K_ADD    = 5'd1;
    localparam logic [KIND_W-1:0] K_SUB    = 5'd2;
    localparam logic [KIND_W-1:0] K_MUL    = 5'd3;
    localparam logic [KIND_W-1:0] K_DIV    = 5'd4;
    localparam logic [KIND_W-1:0] K_REM    = 5'd5;
    localparam logic [KIND_W-1:0] K_MOD    = 5'd6;
    localparam logic [KIND_W-1:0] K_MORE   = 5'd7;
    localparam logic [KIND_W-1:0] K_LESS   = 5'd8;
    localparam logic [KIND_W-1:0] K_EQ     = 5'd9;
    localparam logic [KIND_W-1:0] K_NE     = 5'd10;
    localparam logic [KIND_W-1:0] K_AND    = 5'd11;
    localparam logic [KIND_W-1:0] K_OR     = 5'd12;
    localparam logic [KIND_W-1:0] K_INV    = 5'd13;
    localparam logic [KIND_W-1:0] K_EMIT   = 5'd14;
    localparam logic [KIND_W-1:0] K_KEY    = 5'd15;
    localparam logic [KIND_W-1:0] K_DUP    = 5'd16;
    localparam logic [KIND_W-1:0] K_DROP   = 5'd17;
    localparam logic [KIND_W-1:0] K_SWAP   = 5'd18;
    localparam logic [KIND_W-1:0] K_OVER   = 5'd19;
    localparam logic [KIND_W-1:0] K_ROT    = 5'd20;
    localparam logic [KIND_W-1:0] K_TO_R   = 5'd21;
    localparam logic [KIND_W-1:0] K_R_FROM = 5'd22;
    localparam logic [KIND_W-1:0] K_R_FET  = 5'd23;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUNDER  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DOVER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RUNDER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ROVER   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd5;

endpackage

FILE: rtl/dual_stack_primitive_unit.sv
// Forth-style dual-stack primitive unit.
// Command channel (cmd_valid/cmd_stall) carries one primitive per transaction:
// kind, literal and key_char. Response channel (rsp_valid/rsp_stall) returns one
// transaction per command: status, emit_valid/emit_char, top_value and both
// stack depths after the command.
// Both stacks are chains of word cells with the top in cell 0; every push or
// pop shifts the whole chain by one cell at once.
// Stack, logic, add, subtract and compare primitives respond in the cycle after
// the command is taken; these take one command per cycle while the response
// side does not stall. mul runs on a single 32x32 multiplier in 3 passes and
// responds once they finish; the next command is taken after the unit is idle.
// div, rem and mod use a radix-2 restoring divider, 64 steps plus sign and
// floor fixup; the response and the next command then follow as for mul.
// One command is in flight at a time. The response sits in an output
// register; a new command is taken while the previous response is being
// taken. While rsp_stall is high and a response waits, cmd_stall stays high.
// Reset empties both stacks (depths 0) and clears the response valid flag.
// Stack cells hold no reset value; only entries below a depth are read.
module dual_stack_primitive_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [dsp_pkg::KIND_W-1:0]          kind,
    input  logic signed [dsp_pkg::WORD_W-1:0]   literal,
    input  logic signed [dsp_pkg::KEY_W-1:0]    key_char,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [dsp_pkg::STATUS_W-1:0]        status,
    output logic                                emit_valid,
    output logic [dsp_pkg::CHAR_W-1:0]          emit_char,
    output logic signed [dsp_pkg::WORD_W-1:0]   top_value,
    output logic [dsp_pkg::DEPTH_OUT_W-1:0]     data_depth,
    output logic [dsp_pkg::DEPTH_OUT_W-1:0]     return_depth
);
    import dsp_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t             state_reg;
    logic [DP_W-1:0]    dp_reg;
    logic [DP_W-1:0]    dp_next;
    logic [RP_W-1:0]    rp_reg;
    logic [RP_W-1:0]    rp_next;
    logic               rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic               emit_valid_reg;
    logic [CHAR_W-1:0]  emit_char_reg;
    word_t              top_reg;
    logic [DEPTH_OUT_W-1:0] ddepth_reg;
    logic [DEPTH_OUT_W-1:0] rdepth_reg;

    word_t              d_val [DATA_DEPTH];
    word_t              r_val [RETURN_DEPTH];
    cell_shift_t        d_shift;
    logic [2:0]         d_ld_en;
    word_t              d_ld_val [3];
    cell_shift_t        r_shift;
    logic               r_ld_en;
    word_t              r_ld_val;

    word_t              ta;
    word_t              tb;
    word_t              tc;
    word_t              rtop;
    word_t              key_word;
    word_t              alu_res;
    word_t              top_new;

    logic               out_free;
    logic               cmd_fire;
    logic               go_busy;
    logic               write_rsp;
    logic [STATUS_W-1:0] status_c;
    logic               emit_c;
    arith_req_t         ar_req;
    logic               ar_done;
    word_t              ar_result;

    assign tc   = d_val[0];
    assign tb   = d_val[1];
    assign ta   = d_val[2];
    assign rtop = r_val[0];
    assign key_word = {{(WORD_W-KEY_W){key_char[KEY_W-1]}}, key_char};

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = !((state_reg == S_IDLE) && out_free);
    assign cmd_fire  = cmd_valid && !cmd_stall;

    always_comb
    begin
        case (kind)
            K_ADD:   alu_res = tb + tc;
            K_SUB:   alu_res = tb - tc;
            K_MORE:  alu_res = {WORD_W{$signed(tc) < $signed(tb)}};
            K_LESS:  alu_res = {WORD_W{$signed(tb) < $signed(tc)}};
            K_EQ:    alu_res = {WORD_W{tb == tc}};
            K_NE:    alu_res = {WORD_W{tb != tc}};
            K_AND:   alu_res = tb & tc;
            default: alu_res = tb | tc;
        endcase
    end

    always_comb
    begin
        d_shift     = SHIFT_HOLD;
        d_ld_en     = '0;
        d_ld_val[0] = tc;
        d_ld_val[1] = tb;
        d_ld_val[2] = ta;
        r_shift     = SHIFT_HOLD;
        r_ld_en     = 1'b0;
        r_ld_val    = tc;
        status_c    = ST_OK;
        emit_c      = 1'b0;
        dp_next     = dp_reg;
        rp_next     = rp_reg;
        ar_req.start = 1'b0;
        ar_req.op    = AR_MUL;
        go_busy     = 1'b0;

        if (state_reg == S_BUSY)
        begin
            if (ar_done && out_free)
            begin
                d_shift     = SHIFT_NEXT;
                d_ld_en[0]  = 1'b1;
                d_ld_val[0] = ar_result;
                dp_next     = dp_reg - DP_W'(1);
            end
        end
        else if (cmd_fire)
        begin
            case (kind)
                K_LIT, K_KEY:
                begin
                    if (dp_reg == DP_W'(DATA_DEPTH))
                        status_c = ST_DOVER;
                    else
                    begin
                        d_shift     = SHIFT_PREV;
                        d_ld_en[0]  = 1'b1;
                        d_ld_val[0] = (kind == K_LIT) ? literal : key_word;
                        dp_next     = dp_reg + DP_W'(1);
                    end
                end
                K_ADD, K_SUB, K_MORE, K_LESS, K_EQ, K_NE, K_AND, K_OR:
                begin
                    if (dp_reg < DP_W'(2))
                        status_c = ST_DUNDER;
                    else
                    begin
                        d_shift     = SHIFT_NEXT;
                        d_ld_en[0]  = 1'b1;
                        d_ld_val[0] = alu_res;
                        dp_next     = dp_reg - DP_W'(1);
                    end
                end
                K_MUL, K_DIV, K_REM, K_MOD:
                begin
                    if (dp_reg < DP_W'(2))
                        status_c = ST_DUNDER;
                    else if ((kind != K_MUL) && (tc == '0))
                        status_c = ST_DIVZERO;
                    else
                    begin
                        ar_req.start = 1'b1;
                        case (kind)
                            K_DIV:   ar_req.op = AR_DIV;
                            K_REM:   ar_req.op = AR_REM;
                            K_MOD:   ar_req.op = AR_MOD;
                            default: ar_req.op = AR_MUL;
                        endcase
                        go_busy = 1'b1;
                    end
                end
                K_INV:
                begin
                    if (dp_reg == '0)
                        status_c = ST_DUNDER;
                    else
                    begin
                        d_ld_en[0]  = 1'b1;
                        d_ld_val[0] = ~tc;
                    end
                end
                K_EMIT, K_DROP:
                begin
                    if (dp_reg == '0)
                        status_c = ST_DUNDER;
                    else
                    begin
                        emit_c  = (kind == K_EMIT);
                        d_shift = SHIFT_NEXT;
                        dp_next = dp_reg - DP_W'(1);
                    end
                end
                K_DUP, K_OVER:
                begin
                    if (dp_reg < ((kind == K_DUP) ? DP_W'(1) : DP_W'(2)))
                        status_c = ST_DUNDER;
                    else if (dp_reg == DP_W'(DATA_DEPTH))
                        status_c = ST_DOVER;
                    else
                    begin
                        d_shift     = SHIFT_PREV;
                        d_ld_en[0]  = 1'b1;
                        d_ld_val[0] = (kind == K_DUP) ? tc : tb;
                        dp_next     = dp_reg + DP_W'(1);
                    end
                end
                K_SWAP:
                begin
                    if (dp_reg < DP_W'(2))
                        status_c = ST_DUNDER;
                    else
                    begin
                        d_ld_en[1:0] = 2'b11;
                        d_ld_val[0]  = tb;
                        d_ld_val[1]  = tc;
                    end
                end
                K_ROT:
                begin
                    if (dp_reg < DP_W'(3))
                        status_c = ST_DUNDER;
                    else
                    begin
                        d_ld_en     = 3'b111;
                        d_ld_val[0] = ta;
                        d_ld_val[1] = tc;
                        d_ld_val[2] = tb;
                    end
                end
                K_TO_R:
                begin
                    if (dp_reg == '0)
                        status_c = ST_DUNDER;
                    else if (rp_reg == RP_W'(RETURN_DEPTH))
                        status_c = ST_ROVER;
                    else
                    begin
                        d_shift = SHIFT_NEXT;
                        dp_next = dp_reg - DP_W'(1);
                        r_shift = SHIFT_PREV;
                        r_ld_en = 1'b1;
                        rp_next = rp_reg + RP_W'(1);
                    end
                end
                K_R_FROM, K_R_FET:
                begin
                    if (rp_reg == '0)
                        status_c = ST_RUNDER;
                    else if (dp_reg == DP_W'(DATA_DEPTH))
                        status_c = ST_DOVER;
                    else
                    begin
                        d_shift     = SHIFT_PREV;
                        d_ld_en[0]  = 1'b1;
                        d_ld_val[0] = rtop;
                        dp_next     = dp_reg + DP_W'(1);
                        if (kind == K_R_FROM)
                        begin
                            r_shift = SHIFT_NEXT;
                            rp_next = rp_reg - RP_W'(1);
                        end
                    end
                end
                default:
                begin
                    status_c = ST_OK;
                end
            endcase
        end
    end

    assign write_rsp = (cmd_fire && !go_busy) ||
                       ((state_reg == S_BUSY) && ar_done && out_free);

    always_comb
    begin
        if (d_ld_en[0])
            top_new = d_ld_val[0];
        else if (d_shift == SHIFT_NEXT)
            top_new = tb;
        else
            top_new = tc;
    end

    for (genvar i = 0; i < DATA_DEPTH; i++)
    begin : g_dcell
        cell_ctrl_t ctl;
        word_t      lv;
        word_t      pv;
        word_t      nv;

        assign ctl.shift = d_shift;
        if (i < 3)
        begin : g_ld
            assign ctl.load = d_ld_en[i];
            assign lv       = d_ld_val[i];
        end
        else
        begin : g_nold
            assign ctl.load = 1'b0;
            assign lv       = '0;
        end
        if (i == 0)
        begin : g_first
            assign pv = '0;
        end
        else
        begin : g_mid
            assign pv = d_val[i-1];
        end
        if (i == DATA_DEPTH - 1)
        begin : g_last
            assign nv = '0;
        end
        else
        begin : g_inner
            assign nv = d_val[i+1];
        end

        dsp_cell u_cell (
            .clk        (clk),
            .ctrl       (ctl),
            .load_value (lv),
            .prev_value (pv),
            .next_value (nv),
            .value      (d_val[i])
        );
    end

    for (genvar i = 0; i < RETURN_DEPTH; i++)
    begin : g_rcell
        cell_ctrl_t ctl;
        word_t      pv;
        word_t      nv;

        assign ctl.shift = r_shift;
        assign ctl.load  = (i == 0) ? r_ld_en : 1'b0;
        if (i == 0)
        begin : g_first
            assign pv = '0;
        end
        else
        begin : g_mid
            assign pv = r_val[i-1];
        end
        if (i == RETURN_DEPTH - 1)
        begin : g_last
            assign nv = '0;
        end
        else
        begin : g_inner
            assign nv = r_val[i+1];
        end

        dsp_cell u_cell (
            .clk        (clk),
            .ctrl       (ctl),
            .load_value (r_ld_val),
            .prev_value (pv),
            .next_value (nv),
            .value      (r_val[i])
        );
    end

    dsp_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ar_req),
        .x      (tb),
        .y      (tc),
        .done   (ar_done),
        .result (ar_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dp_reg        <= '0;
            rp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            dp_reg <= dp_next;
            rp_reg <= rp_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (go_busy)
                        state_reg <= S_BUSY;
                end
                default:
                begin
                    if (ar_done && out_free)
                        state_reg <= S_IDLE;
                end
            endcase
            if (write_rsp)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_rsp)
        begin
            status_reg     <= status_c;
            emit_valid_reg <= emit_c;
            emit_char_reg  <= emit_c ? tc[CHAR_W-1:0] : '0;
            top_reg        <= (dp_next == '0) ? '0 : top_new;
            ddepth_reg     <= DEPTH_OUT_W'(dp_next);
            rdepth_reg     <= DEPTH_OUT_W'(rp_next);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign emit_valid   = emit_valid_reg;
    assign emit_char    = emit_char_reg;
    assign top_value    = top_reg;
    assign data_depth   = ddepth_reg;
    assign return_depth = rdepth_reg;

    a_dp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dp_reg <= DP_W'(DATA_DEPTH))
        else $error("data depth beyond capacity");

    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= RP_W'(RETURN_DEPTH))
        else $error("return depth beyond capacity");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> (rsp_valid || state_reg == S_BUSY))
        else $error("accepted transaction produced no response or busy state");

    a_busy_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUSY && !ar_done) |=> $stable(dp_reg) && $stable(rp_reg))
        else $error("stack depth moved while arithmetic in progress");

endmodule

FILE: rtl/dsp_cell.sv
module dsp_cell (
    input  logic               clk,
    input  dsp_pkg::cell_ctrl_t ctrl,
    input  dsp_pkg::word_t     load_value,
    input  dsp_pkg::word_t     prev_value,
    input  dsp_pkg::word_t     next_value,
    output dsp_pkg::word_t     value
);
    import dsp_pkg::*;

    word_t value_reg;
    word_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = load_value;
        end
        else
        begin
            case (ctrl.shift)
                SHIFT_PREV: value_next = prev_value;
                SHIFT_NEXT: value_next = next_value;
                default:    value_next = value_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: rtl/dsp_arith.sv
module dsp_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  dsp_pkg::arith_req_t req,
    input  dsp_pkg::word_t      x,
    input  dsp_pkg::word_t      y,
    output logic                done,
    output dsp_pkg::word_t      result
);
    import dsp_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_SIGN,
        U_MOD,
        U_DONE
    } ustate_t;

    ustate_t           state_reg;
    arith_op_t         op_reg;
    word_t             x_reg;
    word_t             y_reg;
    word_t             quo_reg;
    word_t             rem_reg;
    word_t             dvs_reg;
    word_t             acc_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    word_t             prod;
    word_t             rem_shift;
    logic [WORD_W:0]   diff;
    word_t             mod_val;

    function automatic word_t magnitude(input word_t v);
        return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    endfunction

    assign mul_a = (cnt_reg == CNT_W'(2)) ? x_reg[WORD_W-1:HALF_W] : x_reg[HALF_W-1:0];
    assign mul_b = (cnt_reg == CNT_W'(1)) ? y_reg[WORD_W-1:HALF_W] : y_reg[HALF_W-1:0];
    assign prod  = WORD_W'(mul_a) * WORD_W'(mul_b);

    assign rem_shift = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
    assign diff      = {1'b0, rem_shift} - {1'b0, dvs_reg};

    assign mod_val = ((rem_reg != '0) && (rem_reg[WORD_W-1] != y_reg[WORD_W-1]))
                     ? rem_reg + y_reg : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            op_reg    <= AR_MUL;
            x_reg     <= '0;
            y_reg     <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                U_MUL:
                begin
                    if (cnt_reg == '0)
                        acc_reg <= prod;
                    else
                        acc_reg <= acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(2))
                        state_reg <= U_DONE;
                end
                U_DIV:
                begin
                    if (!diff[WORD_W])
                    begin
                        rem_reg <= diff[WORD_W-1:0];
                        quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == {CNT_W{1'b1}})
                        state_reg <= U_SIGN;
                end
                U_SIGN:
                begin
                    if (x_reg[WORD_W-1] ^ y_reg[WORD_W-1])
                        quo_reg <= ~quo_reg + WORD_W'(1);
                    if (x_reg[WORD_W-1])
                        rem_reg <= ~rem_reg + WORD_W'(1);
                    state_reg <= U_MOD;
                end
                U_MOD:
                begin
                    case (op_reg)
                        AR_DIV:  acc_reg <= quo_reg;
                        AR_REM:  acc_reg <= rem_reg;
                        default: acc_reg <= mod_val;
                    endcase
                    state_reg <= U_DONE;
                end
                default:
                begin
                    if (req.start)
                    begin
                        op_reg  <= req.op;
                        x_reg   <= x;
                        y_reg   <= y;
                        quo_reg <= magnitude(x);
                        dvs_reg <= magnitude(y);
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= (req.op == AR_MUL) ? U_MUL : U_DIV;
                    end
                end
            endcase
        end
    end

    assign done   = (state_reg == U_DONE);
    assign result = acc_reg;

endmodule
